// ----- sv/dusd_pkg.sv -----
// shared types, constants and character helpers for the data uri decoder
// no dependencies
package dusd_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SYNTAX  = 2'd1;
    localparam logic [1:0] ST_ENCODE  = 2'd2;
    localparam logic [1:0] ST_TOOLONG = 2'd3;

    typedef enum logic [3:0] {
        PH_PREFIX  = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_FAIL    = 4'b1000
    } t_phase;

    // one queue entry: up to three data words and an optional closing word
    typedef struct packed {
        logic [1:0]      ndata;
        logic [2:0][7:0] data;
        logic            close;
        logic [1:0]      status;
        logic            mode;
        logic [15:0]     mlen;
    } t_cmd;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a) r = c + 8'h20;
        return r;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] p);
        logic [7:0] r;
        case (p)
            3'd0: r = "d";
            3'd1: r = "a";
            3'd2: r = "t";
            3'd3: r = "a";
            3'd4: r = ":";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] b64_word_char(input logic [2:0] p);
        logic [7:0] r;
        case (p)
            3'd0: r = "b";
            3'd1: r = "a";
            3'd2: r = "s";
            3'd3: r = "e";
            3'd4: r = "6";
            3'd5: r = "4";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
        else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
        else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // {valid, sextet}
    function automatic logic [6:0] b64_digit(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= "A" && c <= "Z") r = {1'b1, 6'(c - 8'h41)};
        else if (c >= "a" && c <= "z") r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        else if (c >= "0" && c <= "9") r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        else if (c == "+") r = {1'b1, 6'd62};
        else if (c == "/") r = {1'b1, 6'd63};
        return r;
    endfunction

endpackage

// ----- sv/data_uri_stream_decoder.sv -----
// top level of the streaming data uri decoder
// depends on dusd_pkg, dusd_front, dusd_queue, dusd_back
//
// input channel: push/full carries one uri character and a last flag;
// a word is taken when push is high and full is low, one per cycle.
// result channel: while empty is low the oldest result word sits on the
// o_ ports; pop takes it. each input causes zero to four result words:
// decoded bytes, then on the last character a closing word with status,
// mode and mime length. a result can be popped the cycle after its input
// is taken. the front end updates its state in the same cycle it takes a
// character and drops at most one entry into a four-deep queue; the back end
// hands out one result word a cycle while pop is high, so sustained input
// rate is one character per cycle while the results per character average
// one or less, and full rises when the queue fills behind a stalled receiver.
// configuration: i_cfg_valid/o_cfg_ready write max_payload_bytes; ready
// is always high. reset (synchronous, active low) empties the queue,
// restores the limit to its maximum and starts a new uri.
module data_uri_stream_decoder #(
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_uri_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_byte,
    output logic        o_data_valid,
    output logic        o_run_last,
    output logic        o_uri_done,
    output logic [1:0]  o_status,
    output logic        o_was_base64,
    output logic [15:0] o_mime_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);
    import dusd_pkg::*;

    t_cmd cmd, head;
    logic cmd_push, deq, q_empty;

    assign o_cfg_ready = 1'b1;
    assign empty       = q_empty;

    dusd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_take      (push && !full),
        .i_uri_byte  (i_uri_byte),
        .i_last_byte (i_last_byte),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd)
    );

    dusd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_push),
        .i_wr_cmd (cmd),
        .i_rd     (deq),
        .o_head   (head),
        .o_full   (full),
        .o_empty  (q_empty)
    );

    dusd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_head_valid  (!q_empty),
        .i_pop         (pop),
        .o_deq         (deq),
        .o_data_byte   (o_data_byte),
        .o_data_valid  (o_data_valid),
        .o_run_last    (o_run_last),
        .o_uri_done    (o_uri_done),
        .o_status      (o_status),
        .o_was_base64  (o_was_base64),
        .o_mime_length (o_mime_length)
    );

`ifndef SYNTH
    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_uri_done) |-> o_run_last)
        else $error("closing word not marked run last");
    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data_valid) |-> (o_status == ST_OK && !o_uri_done))
        else $error("data word carries closing fields");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data_byte) && $stable(o_uri_done)))
        else $error("stalled result changed");
`endif
endmodule

// ----- sv/dusd_front.sv -----
// front end: accepts uri bytes, tracks prefix/header/payload state and
// builds at most one queue entry per byte; depends on dusd_pkg
module dusd_front #(
    parameter int COUNT_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [23:0]   i_cfg_data,
    input  logic          i_take,
    input  logic [7:0]    i_uri_byte,
    input  logic          i_last_byte,
    output logic          o_cmd_push,
    output dusd_pkg::t_cmd o_cmd
);
    import dusd_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [23:0]           r_max, n_max;
    t_phase                r_phase, n_phase;
    logic [2:0]            r_ppos, n_ppos;
    logic [15:0]           r_mime, n_mime;
    logic                  r_first, n_first;
    logic [2:0]            r_spos, n_spos;
    logic                  r_smis, n_smis;
    logic                  r_b64, n_b64;
    logic [COUNT_BITS-1:0] r_pcnt, n_pcnt;
    logic [23:0]           r_acc, n_acc;
    logic [1:0]            r_sext, n_sext;
    logic [1:0]            r_pad, n_pad;
    logic [7:0]            r_held1, n_held1;
    logic [1:0]            r_hcnt, n_hcnt;
    logic [1:0]            r_err, n_err;

    logic [COUNT_BITS+1:0] lim_b64;
    logic                  too_long;
    t_cmd                  cmd;
    logic [7:0]            c;
    logic [6:0]            bd;
    logic [4:0]            hhi, hlo;
    logic [23:0]           acc_sh;

    assign c   = i_uri_byte;
    assign bd  = b64_digit(c);
    assign hhi = hex_digit(r_held1);
    assign hlo = hex_digit(c);
    assign acc_sh = {r_acc[17:0], bd[5:0]};

    always_comb begin
        n_max   = r_max;
        n_phase = r_phase;
        n_ppos  = r_ppos;
        n_mime  = r_mime;
        n_first = r_first;
        n_spos  = r_spos;
        n_smis  = r_smis;
        n_b64   = r_b64;
        n_pcnt  = r_pcnt;
        n_acc   = r_acc;
        n_sext  = r_sext;
        n_pad   = r_pad;
        n_held1 = r_held1;
        n_hcnt  = r_hcnt;
        n_err   = r_err;
        cmd     = '0;
        lim_b64 = '0;
        too_long = 1'b0;
        if (i_cfg_valid) n_max = i_cfg_data;
        if (i_take) begin
            case (r_phase)
                PH_PREFIX: begin
                    if (r_ppos >= 3'd5 || to_lower(c) != prefix_char(r_ppos)) begin
                        n_phase = PH_FAIL;
                        n_err   = ST_SYNTAX;
                    end else begin
                        n_ppos = r_ppos + 3'd1;
                        if (r_ppos == 3'd4) n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (c == "," || c == ";") begin
                        if (r_first) n_first = 1'b0;
                        else if (!r_smis && r_spos == 3'd6) n_b64 = 1'b1;
                        n_spos = 3'd0;
                        n_smis = 1'b0;
                        if (c == ",") n_phase = PH_PAYLOAD;
                    end else if (r_first) begin
                        if (r_mime != 16'hffff) n_mime = r_mime + 16'd1;
                    end else if (!r_smis && r_spos < 3'd6
                                 && to_lower(c) == b64_word_char(r_spos)) begin
                        n_spos = r_spos + 3'd1;
                    end else begin
                        n_smis = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_pcnt != COUNT_MAX) n_pcnt = r_pcnt + 1'b1;
                    if (r_err == ST_OK && r_b64) begin
                        if (c == 8'h0a || c == 8'h0d || c == 8'h20 || c == 8'h09) begin
                            n_acc = r_acc;
                        end else if (c == "=") begin
                            if (r_pad == 2'd2 || r_pad == 2'd3) n_err = ST_ENCODE;
                            else n_pad = r_pad + 2'd1;
                        end else if (r_pad != 2'd0) begin
                            n_err = ST_ENCODE;
                        end else if (!bd[6]) begin
                            n_err = ST_ENCODE;
                        end else if (r_sext == 2'd3) begin
                            cmd.data[0] = acc_sh[23:16];
                            cmd.data[1] = acc_sh[15:8];
                            cmd.data[2] = acc_sh[7:0];
                            cmd.ndata   = 2'd3;
                            n_sext = 2'd0;
                            n_acc  = '0;
                        end else begin
                            n_acc  = acc_sh;
                            n_sext = r_sext + 2'd1;
                        end
                    end else if (r_err == ST_OK) begin
                        if (r_hcnt == 2'd0) begin
                            if (c == "%") n_hcnt = 2'd1;
                            else begin
                                cmd.data[0] = c;
                                cmd.ndata   = 2'd1;
                            end
                        end else if (r_hcnt == 2'd1) begin
                            n_held1 = c;
                            n_hcnt  = 2'd2;
                        end else begin
                            if (hhi[4] && hlo[4]) begin
                                cmd.data[0] = {hhi[3:0], hlo[3:0]};
                                cmd.ndata   = 2'd1;
                            end else begin
                                n_err = ST_ENCODE;
                            end
                            n_hcnt = 2'd0;
                        end
                        // a percent cut short by the end of the uri goes out as text
                        if (i_last_byte && n_err == ST_OK) begin
                            if (n_hcnt != 2'd0) begin
                                cmd.data[cmd.ndata] = "%";
                                cmd.ndata = cmd.ndata + 2'd1;
                            end
                            if (n_hcnt == 2'd2) begin
                                cmd.data[cmd.ndata] = n_held1;
                                cmd.ndata = cmd.ndata + 2'd1;
                            end
                            n_hcnt = 2'd0;
                        end
                    end
                end
                PH_FAIL: begin
                    n_err = r_err;
                end
                default: begin
                    n_phase = PH_FAIL;
                end
            endcase

            if (i_last_byte) begin
                cmd.close = 1'b1;
                if (n_phase == PH_PAYLOAD) begin
                    lim_b64 = {4'b0000, n_pcnt[COUNT_BITS-1:2]} + 1'b1;
                    lim_b64 = (lim_b64 << 1) + lim_b64;
                    if (n_b64)
                        too_long = lim_b64 > (COUNT_BITS+2)'(n_max);
                    else
                        too_long = (COUNT_BITS+2)'(n_pcnt) > (COUNT_BITS+2)'(n_max);
                    if (too_long) cmd.status = ST_TOOLONG;
                    else if (n_err != ST_OK) cmd.status = n_err;
                    else if (n_b64 && n_sext == 2'd1) cmd.status = ST_ENCODE;
                    else begin
                        cmd.status = ST_OK;
                        if (n_b64 && n_sext == 2'd2) begin
                            cmd.data[cmd.ndata] = n_acc[11:4];
                            cmd.ndata = cmd.ndata + 2'd1;
                        end else if (n_b64 && n_sext == 2'd3) begin
                            cmd.data[cmd.ndata] = n_acc[17:10];
                            cmd.data[cmd.ndata+2'd1] = n_acc[9:2];
                            cmd.ndata = cmd.ndata + 2'd2;
                        end
                    end
                    cmd.mode = n_b64;
                    cmd.mlen = n_mime;
                end else begin
                    cmd.status = ST_SYNTAX;
                end
                // back to the start of a new uri
                n_phase = PH_PREFIX;
                n_ppos  = '0;
                n_mime  = '0;
                n_first = 1'b1;
                n_spos  = '0;
                n_smis  = 1'b0;
                n_b64   = 1'b0;
                n_pcnt  = '0;
                n_acc   = '0;
                n_sext  = '0;
                n_pad   = '0;
                n_hcnt  = '0;
                n_err   = ST_OK;
            end
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = i_take && (cmd.close || cmd.ndata != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= 24'hffffff;
            r_phase <= PH_PREFIX;
            r_ppos  <= '0;
            r_mime  <= '0;
            r_first <= 1'b1;
            r_spos  <= '0;
            r_smis  <= 1'b0;
            r_b64   <= 1'b0;
            r_pcnt  <= '0;
            r_acc   <= '0;
            r_sext  <= '0;
            r_pad   <= '0;
            r_hcnt  <= '0;
            r_err   <= ST_OK;
        end else begin
            r_max   <= n_max;
            r_phase <= n_phase;
            r_ppos  <= n_ppos;
            r_mime  <= n_mime;
            r_first <= n_first;
            r_spos  <= n_spos;
            r_smis  <= n_smis;
            r_b64   <= n_b64;
            r_pcnt  <= n_pcnt;
            r_acc   <= n_acc;
            r_sext  <= n_sext;
            r_pad   <= n_pad;
            r_hcnt  <= n_hcnt;
            r_err   <= n_err;
        end
        r_held1 <= n_held1;
    end
endmodule

// ----- sv/dusd_queue.sv -----
// short command queue between front and back ends
// depends on dusd_pkg
module dusd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  dusd_pkg::t_cmd i_wr_cmd,
    input  logic           i_rd,
    output dusd_pkg::t_cmd o_head,
    output logic           o_full,
    output logic           o_empty
);
    import dusd_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            wr_ok, rd_ok;

    assign o_full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = wr_ok ? r_wp + 1'b1 : r_wp;
        n_rp  = rd_ok ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (Q_AW+1)'(wr_ok) - (Q_AW+1)'(rd_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (wr_ok) r_mem[r_wp] <= i_wr_cmd;
    end
endmodule

// ----- sv/dusd_back.sv -----
// back end: walks the head queue entry one result word at a time
// depends on dusd_pkg
module dusd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dusd_pkg::t_cmd i_head,
    input  logic           i_head_valid,
    input  logic           i_pop,
    output logic           o_deq,
    output logic [7:0]     o_data_byte,
    output logic           o_data_valid,
    output logic           o_run_last,
    output logic           o_uri_done,
    output logic [1:0]     o_status,
    output logic           o_was_base64,
    output logic [15:0]    o_mime_length
);
    import dusd_pkg::*;

    logic [1:0] r_sub, n_sub;
    logic [2:0] total;
    logic       is_data, at_end, take;

    assign total   = {1'b0, i_head.ndata} + {2'b00, i_head.close};
    assign is_data = r_sub < i_head.ndata;
    assign at_end  = {1'b0, r_sub} == total - 3'd1;
    assign take    = i_pop && i_head_valid;
    assign o_deq   = take && at_end;

    assign o_data_byte   = is_data ? i_head.data[r_sub] : 8'h00;
    assign o_data_valid  = is_data;
    assign o_run_last    = at_end;
    assign o_uri_done    = !is_data;
    assign o_status      = is_data ? ST_OK : i_head.status;
    assign o_was_base64  = is_data ? 1'b0 : i_head.mode;
    assign o_mime_length = is_data ? 16'h0000 : i_head.mlen;

    always_comb begin
        n_sub = r_sub;
        if (take) n_sub = at_end ? 2'd0 : r_sub + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sub <= '0;
        else          r_sub <= n_sub;
    end
endmodule
